### sv/fcs_pkg.sv
package fcs_pkg;

  // Table size in bytes and fixed cluster size.
  localparam int TABLE_BYTES_DEF = 8192;
  localparam int CLUSTER_SHIFT   = 9;

  // Chain test bounds for a cluster that points into file data.
  localparam logic [11:0] FIRST_VALID = 12'h003;
  localparam logic [11:0] LAST_VALID  = 12'hFF7;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_SEEK = 1'b1
  } opcode_t;

  // Byte write into the table.
  typedef struct packed {
    logic        en;
    logic [12:0] addr;
    logic [7:0]  data;
  } tbl_wr_t;

  // Entry lookup for one cluster.
  typedef struct packed {
    logic        en;
    logic [11:0] cluster;
  } tbl_rd_t;

endpackage

### sv/fcs_table.sv
module fcs_table
  import fcs_pkg::*;
#(
  parameter int TABLE_BYTES = TABLE_BYTES_DEF
) (
  input  logic        clk,
  input  tbl_wr_t     wr,
  input  tbl_rd_t     rd,
  output logic [11:0] entry
);

  localparam int EVEN_DEPTH = (TABLE_BYTES + 1) / 2;
  localparam int ODD_DEPTH  = TABLE_BYTES / 2;
  localparam int EIDX_W     = $clog2(EVEN_DEPTH);
  localparam int OIDX_W     = $clog2(ODD_DEPTH);
  localparam logic [13:0] TABLE_BYTES_C = 14'(TABLE_BYTES);
  localparam logic [12:0] EVEN_DEPTH_C  = 13'(EVEN_DEPTH);
  localparam logic [12:0] ODD_DEPTH_C   = 13'(ODD_DEPTH);

  // Even and odd bytes in separate banks so both bytes of an entry
  // come out in one read.
  logic [7:0] even_mem [EVEN_DEPTH];
  logic [7:0] odd_mem  [ODD_DEPTH];

  logic [12:0] pos;
  logic [12:0] pos1;
  logic [11:0] even_word;
  logic [11:0] odd_word;
  logic        even_ok;
  logic        odd_ok;

  logic [7:0] even_q;
  logic [7:0] odd_q;
  logic       even_ok_q;
  logic       odd_ok_q;
  logic       swap_q;
  logic       cl_odd_q;

  logic [7:0]  lo_byte;
  logic [7:0]  hi_byte;
  logic [7:0]  even_b;
  logic [7:0]  odd_b;
  logic [15:0] word;

  assign pos       = {1'b0, rd.cluster} + {2'b00, rd.cluster[11:1]};
  assign pos1      = pos + 13'd1;
  assign even_word = pos1[12:1];
  assign odd_word  = pos[12:1];
  assign even_ok   = {1'b0, even_word} < EVEN_DEPTH_C;
  assign odd_ok    = {1'b0, odd_word} < ODD_DEPTH_C;

  always_ff @(posedge clk) begin
    if (wr.en && ({1'b0, wr.addr} < TABLE_BYTES_C)) begin
      if (wr.addr[0]) begin
        odd_mem[wr.addr[OIDX_W:1]] <= wr.data;
      end else begin
        even_mem[wr.addr[EIDX_W:1]] <= wr.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      even_q    <= even_mem[even_word[EIDX_W-1:0]];
      odd_q     <= odd_mem[odd_word[OIDX_W-1:0]];
      even_ok_q <= even_ok;
      odd_ok_q  <= odd_ok;
      swap_q    <= pos[0];
      cl_odd_q  <= rd.cluster[0];
    end
  end

  // Bytes past the end of the table read as zero.
  assign even_b  = even_ok_q ? even_q : 8'h00;
  assign odd_b   = odd_ok_q ? odd_q : 8'h00;
  assign lo_byte = swap_q ? odd_b : even_b;
  assign hi_byte = swap_q ? even_b : odd_b;
  assign word    = {hi_byte, lo_byte};
  assign entry   = cl_odd_q ? word[15:4] : word[11:0];

endmodule

### sv/fat12_cluster_chain_seek.sv
// FAT12 cluster-chain seek.
//
// Input channel (in_valid / in_stall): each transfer is a load or a seek.
// A load writes one allocation-table byte and gives no result. A seek
// takes a start cluster and a file byte offset, follows the chain
// file_offset / 512 times and gives one result on the output channel
// (out_valid / out_stall): the cluster reached, its disk byte address,
// the offset inside the cluster and a chain validity flag.
// Each of the N chain steps, N being file_offset / 512, is one table
// read (ST_ADDR) and one update (ST_STEP) through the single read port
// of the table memory; ST_DONE then loads the output register. The next
// item is taken only once the seek has gone back to ST_IDLE.
// One item is worked on at a time; in_stall is high while a seek walks.
// The result sits in an output register, so loads and a new seek are
// taken while an earlier result waits; a finished seek holds in its last
// state until the output register is free.
// Reset clears the control state and data_offset; table contents are
// undefined until loaded. data_offset is written through cfg_we/cfg_wdata;
// the user must write it only while the block is idle; the block itself does not enforce this.
module fat12_cluster_chain_seek
  import fcs_pkg::*;
#(
  parameter int TABLE_BYTES = TABLE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic [12:0] table_byte_address,
  input  logic [7:0]  table_byte_value,
  input  logic [11:0] start_cluster,
  input  logic [20:0] file_offset,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] found_cluster,
  output logic [25:0] disk_byte_address,
  output logic [8:0]  offset_in_cluster,
  output logic        cluster_valid
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ADDR = 4'b0010,
    ST_STEP = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t      state;
  state_t      state_next;
  logic [15:0] data_offset;
  logic [11:0] walk_cluster;
  logic [11:0] steps_left;
  logic [8:0]  in_cluster;

  tbl_wr_t     wr;
  tbl_rd_t     rd;
  logic [11:0] entry;

  logic        in_xfer;
  logic        seek_xfer;
  logic        out_free;
  logic        result_load;
  logic [16:0] sector;
  logic [11:0] skip;

  assign in_stall    = (state != ST_IDLE);
  assign in_xfer     = in_valid && !in_stall;
  assign seek_xfer   = in_xfer && (opcode_t'(opcode) == OP_SEEK);
  assign out_free    = !out_valid || !out_stall;
  assign result_load = (state == ST_DONE) && out_free;
  assign skip        = file_offset[20:CLUSTER_SHIFT];

  // Loads only happen in idle and reads only while walking, so a read
  // never meets a write to the same byte.
  assign wr.en   = in_xfer && (opcode_t'(opcode) == OP_LOAD);
  assign wr.addr = table_byte_address;
  assign wr.data = table_byte_value;

  assign rd.en      = (state == ST_ADDR);
  assign rd.cluster = walk_cluster;

  fcs_table #(
    .TABLE_BYTES(TABLE_BYTES)
  ) u_table (
    .clk  (clk),
    .wr   (wr),
    .rd   (rd),
    .entry(entry)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (seek_xfer) begin
          state_next = (skip == 12'd0) ? ST_DONE : ST_ADDR;
        end
      end
      ST_ADDR: begin
        state_next = ST_STEP;
      end
      ST_STEP: begin
        state_next = (steps_left == 12'd1) ? ST_DONE : ST_ADDR;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      data_offset <= 16'd0;
      steps_left  <= 12'd0;
      walk_cluster <= 12'd0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        data_offset <= cfg_wdata;
      end
      if (seek_xfer) begin
        walk_cluster <= start_cluster;
        steps_left   <= skip;
      end else if (state == ST_STEP) begin
        // advance one link of the chain
        walk_cluster <= entry;
        steps_left   <= steps_left - 12'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (seek_xfer) begin
      in_cluster <= file_offset[CLUSTER_SHIFT-1:0];
    end
  end

  // Cluster size is a power of two: the address is the sector number
  // with the in-cluster offset appended.
  assign sector = {1'b0, data_offset} + {5'b00000, walk_cluster};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      found_cluster     <= walk_cluster;
      disk_byte_address <= {sector, in_cluster};
      offset_in_cluster <= in_cluster;
      cluster_valid     <= (walk_cluster >= FIRST_VALID) && (walk_cluster <= LAST_VALID);
    end
  end

`ifndef SYNTHESIS
  a_step_has_work: assert property (@(posedge clk) disable iff (rst)
    (state == ST_STEP) |-> (steps_left != 12'd0))
    else $error("chain step taken with no steps left");

  a_seek_walks: assert property (@(posedge clk) disable iff (rst)
    (seek_xfer && (skip != 12'd0)) |=> (state == ST_ADDR))
    else $error("seek with nonzero skip did not start a walk");

  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    result_load |=> (out_valid && (found_cluster == $past(walk_cluster))))
    else $error("finished seek not presented on output");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    $fell(out_valid) |-> !$past(out_stall))
    else $error("result dropped while stalled");
`endif

endmodule

### bench/fat12_cluster_chain_seek_checker.sv
`timescale 1ns / 100ps
module fat12_cluster_chain_seek_checker
  import fcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        opcode,
  input  logic [12:0] table_byte_address,
  input  logic [7:0]  table_byte_value,
  input  logic [11:0] start_cluster,
  input  logic [20:0] file_offset,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [11:0] found_cluster,
  input  logic [25:0] disk_byte_address,
  input  logic [8:0]  offset_in_cluster,
  input  logic        cluster_valid,
  output int unsigned fail_count,
  output int unsigned results_due
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [11:0] cluster;
    logic [25:0] disk_addr;
    logic [8:0]  in_cluster;
    logic        chain_ok;
  } location_t;

  bit [7:0]    fat_copy [TABLE_BYTES_DEF];
  logic [15:0] sector_bias;
  location_t   due_locations [$];
  int unsigned failures;

  function automatic logic [7:0] fat_byte(int pos);
    if (pos >= TABLE_BYTES_DEF) return 8'h00;
    return fat_copy[pos];
  endfunction

  // Follow the chain offset / 512 times, then form the disk address.
  function automatic location_t locate_byte(logic [11:0] origin, logic [20:0] offs);
    location_t   loc;
    logic [11:0] cl;
    logic [16:0] sector;
    logic [7:0]  b_lo;
    logic [7:0]  b_hi;
    int          steps;
    int          pos;
    cl = origin;
    steps = int'(offs[20:9]);
    for (int i = 0; i < steps; i++) begin
      pos  = int'(cl) + int'(cl >> 1);
      b_lo = fat_byte(pos);
      b_hi = fat_byte(pos + 1);
      if (cl[0]) cl = {b_hi, b_lo[7:4]};
      else cl = {b_hi[3:0], b_lo};
    end
    sector = {1'b0, sector_bias} + {5'd0, cl};
    loc.cluster    = cl;
    loc.disk_addr  = {sector, offs[8:0]};
    loc.in_cluster = offs[8:0];
    loc.chain_ok   = (cl >= FIRST_VALID) && (cl <= LAST_VALID);
    return loc;
  endfunction

  always @(posedge clk) begin
    location_t want;
    location_t got;
    if (rst) begin
      sector_bias = 16'h0000;
      due_locations.delete();
    end else begin
      if (cfg_we) sector_bias = cfg_wdata;
      if (in_valid && !in_stall) begin
        if (opcode_t'(opcode) == OP_LOAD) fat_copy[table_byte_address] = table_byte_value;
        else due_locations.push_back(locate_byte(start_cluster, file_offset));
      end
      if (out_valid && !out_stall) begin
        got = '{found_cluster, disk_byte_address, offset_in_cluster, cluster_valid};
        if (due_locations.size() == 0) begin
          failures++;
          if (failures <= REPORT_LIMIT)
            $display("%0t: unexpected result cluster=%h addr=%h off=%h ok=%b", $time,
                     got.cluster, got.disk_addr, got.in_cluster, got.chain_ok);
        end else begin
          want = due_locations.pop_front();
          if (got !== want) begin
            failures++;
            if (failures <= REPORT_LIMIT)
              $display("%0t: mismatch exp cluster=%h addr=%h off=%h ok=%b, got %h %h %h %b",
                       $time, want.cluster, want.disk_addr, want.in_cluster, want.chain_ok,
                       got.cluster, got.disk_addr, got.in_cluster, got.chain_ok);
          end
        end
      end
    end
    fail_count  <= failures;
    results_due <= unsigned'(due_locations.size());
  end

endmodule

### bench/tb_fat12_cluster_chain_seek.sv
`timescale 1ns / 100ps
module tb_fat12_cluster_chain_seek;
  import fcs_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 12;
  localparam int RANDOM_ITEMS  = 1300;
  localparam int PHASES        = 5;
  // A full 4095-step walk has no transfers while it runs; allow several times its length.
  localparam int QUIET_LIMIT   = 50000;
  // Loads give no result, so let the block finish one before touching config.
  localparam int SETTLE_CYCLES = 4;
  localparam int MAX_STEPS     = 4095;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic        opcode;
  logic [12:0] table_byte_address;
  logic [7:0]  table_byte_value;
  logic [11:0] start_cluster;
  logic [20:0] file_offset;
  logic        out_valid;
  logic        out_stall;
  logic [11:0] found_cluster;
  logic [25:0] disk_byte_address;
  logic [8:0]  offset_in_cluster;
  logic        cluster_valid;

  int unsigned fail_count;
  int unsigned results_due;

  // Stimulus-side image of the table: only walks over written bytes are issued.
  bit [7:0]    fat_img   [TABLE_BYTES_DEF];
  bit          fat_known [TABLE_BYTES_DEF];
  logic [11:0] chain_heads [$];
  int          items_sent;
  int          quiet_cycles;
  bit          quiet;

  // Entry values on and near the chain-test boundaries.
  const logic [11:0] boundary_clusters [6] = '{12'h000, 12'h001, 12'h002,
                                               12'hFF7, 12'hFF8, 12'hFFF};

  always #(HALF_PERIOD) clk = ~clk;

  fat12_cluster_chain_seek u_dut (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .opcode             (opcode),
    .table_byte_address (table_byte_address),
    .table_byte_value   (table_byte_value),
    .start_cluster      (start_cluster),
    .file_offset        (file_offset),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .found_cluster      (found_cluster),
    .disk_byte_address  (disk_byte_address),
    .offset_in_cluster  (offset_in_cluster),
    .cluster_valid      (cluster_valid)
  );

  fat12_cluster_chain_seek_checker u_check (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .opcode             (opcode),
    .table_byte_address (table_byte_address),
    .table_byte_value   (table_byte_value),
    .start_cluster      (start_cluster),
    .file_offset        (file_offset),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .found_cluster      (found_cluster),
    .disk_byte_address  (disk_byte_address),
    .offset_in_cluster  (offset_in_cluster),
    .cluster_valid      (cluster_valid),
    .fail_count         (fail_count),
    .results_due        (results_due)
  );

  // Count how many chain steps from origin stay on written table bytes,
  // capped at the number wanted.
  function automatic int reachable_steps(logic [11:0] origin, int want);
    logic [11:0] cl;
    int          n;
    int          p;
    cl = origin;
    for (n = 0; n < want; n++) begin
      p = int'(cl) + int'(cl >> 1);
      if (!(fat_known[p] && fat_known[p + 1])) break;
      if (cl[0]) cl = {fat_img[p + 1], fat_img[p][7:4]};
      else cl = {fat_img[p + 1][3:0], fat_img[p]};
    end
    return n;
  endfunction

  // Mostly short walks; now and then a deep one that loops through a chain.
  function automatic int pick_depth(int chain_len);
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return $urandom_range(0, MAX_STEPS);
    if (r < 15) return $urandom_range(0, 64);
    return $urandom_range(0, 2 * chain_len + 2);
  endfunction

  // Present one item and hold it until the transfer. A random idle burst
  // may come first; the don't-care fields carry random bits.
  task automatic send_item(opcode_t op, logic [12:0] addr, logic [7:0] val,
                           logic [11:0] first, logic [20:0] offs);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid           <= 1'b1;
    opcode             <= op;
    table_byte_address <= addr;
    table_byte_value   <= val;
    start_cluster      <= first;
    file_offset        <= offs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic load_byte(logic [12:0] addr, logic [7:0] val);
    fat_img[addr]   = val;
    fat_known[addr] = 1'b1;
    send_item(OP_LOAD, addr, val, 12'($urandom), 21'($urandom));
  endtask

  // Write one 12-bit entry as two byte loads, keeping the neighbor's nibble.
  task automatic put_entry(logic [11:0] cl, logic [11:0] val);
    int         p;
    logic [7:0] lo;
    logic [7:0] hi;
    p  = int'(cl) + int'(cl >> 1);
    lo = fat_known[p] ? fat_img[p] : 8'($urandom);
    hi = fat_known[p + 1] ? fat_img[p + 1] : 8'($urandom);
    if (cl[0]) begin
      lo[7:4] = val[3:0];
      hi      = val[11:4];
    end else begin
      lo      = val[7:0];
      hi[3:0] = val[11:8];
    end
    load_byte(13'(p), lo);
    load_byte(13'(p + 1), hi);
  endtask

  // Seek from first, walking as far as wanted but never onto unwritten bytes.
  task automatic seek_from(logic [11:0] first, int want, logic [8:0] in_cl);
    int n;
    n = reachable_steps(first, want > MAX_STEPS ? MAX_STEPS : want);
    send_item(OP_SEEK, 13'($urandom), 8'($urandom), first, {12'(n), in_cl});
  endtask

  // Lay down a short chain of random clusters, close it with a loop, a
  // boundary value or noise, then seek into it.
  task automatic chain_burst();
    logic [11:0] links [$];
    logic [11:0] tail;
    int          len;
    len = $urandom_range(1, 8);
    repeat (len) links.push_back(12'($urandom));
    for (int j = 0; j < len - 1; j++) put_entry(links[j], links[j + 1]);
    case ($urandom_range(0, 3))
      0, 1: tail = links[$urandom_range(0, len - 1)];
      2: tail = boundary_clusters[$urandom_range(0, 5)];
      default: tail = 12'($urandom);
    endcase
    put_entry(links[len - 1], tail);
    repeat ($urandom_range(1, 3))
      seek_from(links[$urandom_range(0, len - 1)], pick_depth(len), 9'($urandom));
    chain_heads.push_back(links[0]);
  endtask

  // Drop valid and wait until every result is in and a last load has finished.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_data_offset(logic [15:0] bias);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= bias;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Output side: stall in random bursts, never in the quiet phase.
  initial begin : stall_gen
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: end the run when nothing transfers for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int          phase_end;
    int          pick;
    logic [15:0] bias;
    quiet              = 1'b0;
    items_sent         = 0;
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_wdata          <= 16'h0000;
    in_valid           <= 1'b0;
    opcode             <= OP_LOAD;
    table_byte_address <= 13'h0000;
    table_byte_value   <= 8'h00;
    start_cluster      <= 12'h000;
    file_offset        <= 21'h000000;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed part, with the largest sector bias.
    set_data_offset(16'hFFFF);
    // Two-cluster loop 2 <-> 3 covers both nibble layouts and the lower
    // chain-test bound; 4 and 5 point at the upper bound and just past it.
    put_entry(12'h002, 12'h003);
    put_entry(12'h003, 12'h002);
    put_entry(12'h004, 12'hFF7);
    put_entry(12'h005, 12'hFF8);
    // Extremes of the load fields.
    load_byte(13'h1FFF, 8'hFF);
    load_byte(13'h0000, 8'h00);
    // Zero skip count: the start cluster comes back with no table read.
    seek_from(12'h000, 0, 9'h000);
    seek_from(12'hFFF, 0, 9'h1FF);
    // One step from each of 2 to 5 lands on the loop, the upper bound and past it; two steps go around the loop.
    seek_from(12'h002, 1, 9'h000);
    seek_from(12'h003, 1, 9'h0AA);
    seek_from(12'h004, 1, 9'h155);
    seek_from(12'h005, 1, 9'h100);
    seek_from(12'h002, 2, 9'h001);
    // Largest offset: 4095 steps around the loop.
    seek_from(12'h002, MAX_STEPS, 9'h1FF);

    // Random part in phases, a new sector bias each time; the last phase
    // runs with no idling on either side.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: bias = 16'h0000;
        2: bias = 16'hFFFF;
        default: bias = 16'($urandom);
      endcase
      set_data_offset(bias);
      quiet     = (phase == PHASES - 1);
      phase_end = items_sent + RANDOM_ITEMS / PHASES;
      while (items_sent < phase_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 60 || chain_heads.size() == 0) begin
          chain_burst();
        end else if (pick < 85) begin
          seek_from(chain_heads[$urandom_range(0, chain_heads.size() - 1)], pick_depth(4),
                    9'($urandom));
        end else begin
          // Stray load: may overwrite chain bytes, which later walks follow.
          load_byte(13'($urandom), 8'($urandom));
        end
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
